FILE: rtl/mrcs_pkg.sv
// package for the masked rgb channel statistics block
// holds sizes, the channel-array types and the statistics record type
// no dependencies
`default_nettype none

package mrcs_pkg;

	// saturation point of the pixel count
	localparam longint MaxPixels = 1048576;

	// widths derived from the saturation point
	localparam int CNT_W = $clog2(MaxPixels + 1);
	localparam int SUM_W = $clog2(MaxPixels * 255 + 1);
	localparam int CHAN_W = 8;
	localparam int NUM_CHAN = 3;
	localparam int CHAN_IDX_W = $clog2(NUM_CHAN);

	// divider sizes: the mean never exceeds one channel value
	localparam int MEAN_W = CHAN_W;
	localparam int DSR_W = CNT_W + MEAN_W - 1;
	localparam int REM_W = CNT_W + MEAN_W;
	localparam int STEP_W = $clog2(MEAN_W);

	// port field widths
	localparam int OUT_CNT_W = 21;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 96;

	// channel index 0 is red, 1 green, 2 blue
	localparam logic [CHAN_IDX_W-1:0] CH_RED = CHAN_IDX_W'(0);
	localparam logic [CHAN_IDX_W-1:0] CH_GREEN = CHAN_IDX_W'(1);
	localparam logic [CHAN_IDX_W-1:0] CH_BLUE = CHAN_IDX_W'(2);

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;

	typedef struct packed {
		logic [CNT_W-1:0]                 count;
		logic                             overflow;
		logic [NUM_CHAN-1:0][CHAN_W-1:0]  low;
		logic [NUM_CHAN-1:0][CHAN_W-1:0]  high;
		logic [NUM_CHAN-1:0][SUM_W-1:0]   sum;
	} mrcs_stats_t;

endpackage

`default_nettype wire

FILE: rtl/mrcs_accum.sv
// running count, sums, minima and maxima over the current segment
// depends on mrcs_pkg
`default_nettype none

module mrcs_accum (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 update,
	input  wire mrcs_pkg::pix_t       pix,
	input  wire logic                 clear,
	output mrcs_pkg::mrcs_stats_t     stats
);
	import mrcs_pkg::*;

	logic [CNT_W-1:0]                count_q;
	logic                            ovf_q;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] low_q;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] high_q;
	logic [NUM_CHAN-1:0][SUM_W-1:0]  sum_q;

	logic nonblack;
	logic saturated;

	assign nonblack = |pix;
	assign saturated = (count_q >= CNT_W'(MaxPixels));

	// segment state, back to reset values after each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			for (int c = 0; c < NUM_CHAN; c++) begin
				low_q[c] <= CHAN_MAX;
				high_q[c] <= '0;
				sum_q[c] <= '0;
			end
		end else if (clear) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			for (int c = 0; c < NUM_CHAN; c++) begin
				low_q[c] <= CHAN_MAX;
				high_q[c] <= '0;
				sum_q[c] <= '0;
			end
		end else if (update && nonblack) begin
			// past saturation only the flag and the extremes move
			if (saturated) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
				for (int c = 0; c < NUM_CHAN; c++) begin
					sum_q[c] <= sum_q[c] + SUM_W'(pix[c]);
				end
			end
			for (int c = 0; c < NUM_CHAN; c++) begin
				if (pix[c] < low_q[c]) begin
					low_q[c] <= pix[c];
				end
				if (pix[c] > high_q[c]) begin
					high_q[c] <= pix[c];
				end
			end
		end
	end

	assign stats.count = count_q;
	assign stats.overflow = ovf_q;
	assign stats.low = low_q;
	assign stats.high = high_q;
	assign stats.sum = sum_q;

endmodule

`default_nettype wire

FILE: rtl/mrcs_divider.sv
// shared restoring divider, one quotient bit per cycle
// a zero divisor gives a zero quotient; depends on mrcs_pkg
`default_nettype none

module mrcs_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mrcs_pkg::REM_W-1:0]    dividend,
	input  wire logic [mrcs_pkg::CNT_W-1:0]    divisor,
	output logic                               busy,
	output logic                               done,
	output logic [mrcs_pkg::MEAN_W-1:0]        quotient
);
	import mrcs_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              zero_q;
	logic [REM_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [MEAN_W-1:0] quo_q;

	logic              fits;
	logic [REM_W-1:0]  rem_diff;
	logic [MEAN_W-1:0] quo_next;

	// one compare and subtract per cycle
	assign fits = (rem_q >= REM_W'(dsr_q));
	assign rem_diff = rem_q - REM_W'(dsr_q);
	assign quo_next = {quo_q[MEAN_W-2:0], fits};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(MEAN_W - 1);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= {divisor, (MEAN_W - 1)'(0)};
			quo_q <= '0;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_diff;
			end
			dsr_q <= dsr_q >> 1;
			quo_q <= quo_next;
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (step_q == '0);
	assign quotient = zero_q ? '0 : quo_next;

endmodule

`default_nettype wire

FILE: rtl/masked_rgb_channel_statistics.sv
// top level: segment statistics with per-channel mean by a shared divider
// depends on mrcs_pkg, mrcs_accum, mrcs_divider
//
//  channel  direction  fields (low bit first)
//  s_axis   in         tdata: pixel_red, pixel_green, pixel_blue; tlast: last_pixel
//  m_axis   out        tdata: pixel_count, count_overflow, min/mean/max red,
//                      min/mean/max green, min/mean/max blue
//
// a pixel without the last mark leaves s_tready high; the next may follow at once
// a last pixel holds s_tready low through three mean divisions, red, green, then blue,
// on the one restoring divider, and through the load of the result
// the finished result waits in an output register while the next segment runs
// a second last pixel waits before loading until the previous result is taken
// arst_n clears the counters, extremes, sequencer and output valid
`default_nettype none

module masked_rgb_channel_statistics (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // pixel_red, pixel_green, pixel_blue
	input  wire logic        s_tlast,  // last_pixel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata   // pixel_count, count_overflow, min_red, mean_red,
	                                   // max_red, min_green, mean_green, max_green,
	                                   // min_blue, mean_blue, max_blue, zero pad
);
	import mrcs_pkg::*;

	localparam logic [1:0] ST_ACC = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0]                      state_q;
	logic [CHAN_IDX_W-1:0]           chan_q;
	logic                            launch_q;
	logic [NUM_CHAN-1:0][MEAN_W-1:0] mean_q;
	logic                            out_valid_q;
	logic [OUT_DATA_W-1:0]           out_data_q;

	logic              accept;
	logic              out_free;
	logic              load;
	logic              div_busy;
	logic              div_done;
	logic [MEAN_W-1:0] div_quo;
	mrcs_stats_t       stats;
	pix_t              pix;

	assign pix = s_tdata;
	assign s_tready = (state_q == ST_ACC);
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign load = (state_q == ST_LOAD) && out_free;

	mrcs_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.update (accept),
		.pix    (pix),
		.clear  (load),
		.stats  (stats)
	);

	mrcs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (launch_q),
		.dividend (REM_W'(stats.sum[chan_q])),
		.divisor  (stats.count),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer: accumulate, divide each channel, load the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			chan_q <= CH_RED;
			launch_q <= 1'b0;
		end else begin
			case (state_q)
				ST_ACC: begin
					launch_q <= accept && s_tlast;
					if (accept && s_tlast) begin
						state_q <= ST_DIV;
						chan_q <= CH_RED;
					end
				end
				ST_DIV: begin
					launch_q <= div_done && (chan_q != CH_BLUE);
					if (div_done) begin
						if (chan_q == CH_BLUE) begin
							state_q <= ST_LOAD;
						end else begin
							chan_q <= chan_q + CHAN_IDX_W'(1);
						end
					end
				end
				ST_LOAD: begin
					launch_q <= 1'b0;
					if (out_free) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					launch_q <= 1'b0;
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	// mean of each channel as it finishes
	always_ff @(posedge clk) begin
		if (div_done) begin
			mean_q[chan_q] <= div_quo;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {2'b00,
				stats.high[CH_BLUE], mean_q[CH_BLUE], stats.low[CH_BLUE],
				stats.high[CH_GREEN], mean_q[CH_GREEN], stats.low[CH_GREEN],
				stats.high[CH_RED], mean_q[CH_RED], stats.low[CH_RED],
				stats.overflow, OUT_CNT_W'(stats.count)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// checks on the sequencer and divider handshake
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> (state_q == ST_DIV) && !div_busy)
		else $error("divider started while busy or outside division");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside division");

	a_last_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (state_q == ST_DIV) && launch_q)
		else $error("last request did not start the divisions");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid && (state_q == ST_ACC))
		else $error("result load did not raise m_tvalid");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(chan_q == CH_RED) || (chan_q == CH_GREEN) || (chan_q == CH_BLUE))
		else $error("channel index out of range");

endmodule

`default_nettype wire

FILE: tb/sv/masked_rgb_channel_statistics_tb.sv
// testbench for masked_rgb_channel_statistics: per-channel min, mean and max over pixel segments
// drives pixel requests, predicts each segment result and checks every result field
// depends on mrcs_pkg and the masked_rgb_channel_statistics rtl
`default_nettype none

module masked_rgb_channel_statistics_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrcs_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PRINT_LIMIT = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // pixel_red, pixel_green, pixel_blue
	logic        s_tlast = 1'b0; // last_pixel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;        // pixel_count, count_overflow, min_red, mean_red, max_red,
	                             // min_green, mean_green, max_green, min_blue, mean_blue,
	                             // max_blue, zero pad

	// segment predictor state
	int unsigned     seg_count;
	bit              seg_overflow;
	longint unsigned chan_sum[3];
	logic [7:0]      chan_low[3];
	logic [7:0]      chan_high[3];

	// predicted segment results, oldest first
	logic [95:0] seg_results_q[$];

	string stat_field[12] = '{"pixel_count", "count_overflow", "min_red", "mean_red", "max_red",
		"min_green", "mean_green", "max_green", "min_blue", "mean_blue", "max_blue", "pad"};

	int  mismatches = 0;
	bit  sender_steady = 1'b0;
	bit  receiver_steady = 1'b0;
	int  hold_cycles = 0;

	masked_rgb_channel_statistics u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always #6 clk = ~clk;

	function automatic void clear_segment();
		seg_count = 0;
		seg_overflow = 1'b0;
		for (int c = 0; c < 3; c++) begin
			chan_sum[c] = 0;
			chan_low[c] = 8'd255;
			chan_high[c] = 8'd0;
		end
	endfunction

	// fold one accepted pixel into the segment, emit the result on the last one
	function automatic void absorb_pixel(input logic [23:0] rgb, input logic last);
		logic [95:0] stats;
		logic [7:0]  v;
		logic [7:0]  mean;
		if (rgb != 24'd0) begin
			// past saturation only the flag and the extremes move
			if (seg_count >= MaxPixels) begin
				seg_overflow = 1'b1;
			end else begin
				seg_count++;
				for (int c = 0; c < 3; c++) chan_sum[c] += rgb[8*c +: 8];
			end
			for (int c = 0; c < 3; c++) begin
				v = rgb[8*c +: 8];
				if (v < chan_low[c]) chan_low[c] = v;
				if (v > chan_high[c]) chan_high[c] = v;
			end
		end
		if (last) begin
			stats = '0;
			stats[20:0] = 21'(seg_count);
			stats[21] = seg_overflow;
			for (int c = 0; c < 3; c++) begin
				mean = (seg_count == 0) ? 8'd0 : 8'(chan_sum[c] / seg_count);
				stats[22 + 24*c +: 24] = {chan_high[c], mean, chan_low[c]};
			end
			seg_results_q = {seg_results_q, stats};
			clear_segment();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// compare one result with the oldest prediction, field by field
	task automatic check_stats(input logic [95:0] got);
		logic [95:0] want;
		logic [95:0] got_f;
		logic [95:0] want_f;
		int          off;
		int          w;
		if (seg_results_q.size() == 0) begin
			report_mismatch("result with no segment pending, pixel_count", 64'(got[20:0]),
				64'd0);
			return;
		end
		want = seg_results_q.pop_front();
		off = 0;
		for (int i = 0; i < 12; i++) begin
			w = (i == 0) ? 21 : (i == 1) ? 1 : (i == 11) ? 2 : 8;
			got_f = (got >> off) & ((96'd1 << w) - 96'd1);
			want_f = (want >> off) & ((96'd1 << w) - 96'd1);
			if (got_f !== want_f) report_mismatch(stat_field[i], 64'(got_f), 64'(want_f));
			off += w;
		end
	endtask

	// input side: predict on every accepted pixel request
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) absorb_pixel(s_tdata, s_tlast);
	end

	// output side: check every accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_stats(m_tdata);
	end

	// receiver: random stalls, steady stretches and long hold-offs
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles--;
		end else if (receiver_steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 33);
		end
	end

	// watchdog on cycles with no request moving on either side
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
			else idle++;
		end
		$display("[%0t] ERROR no progress for %0d cycles", $realtime, IDLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// offer one pixel, return at the edge where it is taken
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input logic last);
		@(negedge clk);
		if (!sender_steady) begin
			while ($urandom_range(99) < 33) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tdata <= {b, g, r};
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait for every predicted result
	task automatic wait_results_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (seg_results_q.size() != 0) @(posedge clk);
	endtask

	// black pixels, channel extremes and full random values
	function automatic logic [23:0] random_pixel();
		logic [23:0] rgb;
		int          kind;
		kind = $urandom_range(9);
		rgb = 24'($urandom);
		if (kind < 2) begin
			rgb = 24'd0;
		end else if (kind < 4) begin
			for (int c = 0; c < 3; c++) begin
				case ($urandom_range(3))
					0: rgb[8*c +: 8] = 8'd0;
					1: rgb[8*c +: 8] = 8'd255;
					2: rgb[8*c +: 8] = 8'd1;
					default: rgb[8*c +: 8] = 8'd254;
				endcase
			end
		end
		return rgb;
	endfunction

	// send one segment of random pixels ending with the last mark
	task automatic send_random_segment(input int len);
		logic [23:0] rgb;
		for (int j = 0; j < len; j++) begin
			rgb = random_pixel();
			send_pixel(rgb[7:0], rgb[15:8], rgb[23:16], j == len - 1);
		end
	endtask

	task automatic test_directed_segments();
		// empty segment: a lone black last pixel
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		// single white pixel and a single pixel with one channel set
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd1, 8'd0, 8'd0, 1'b1);
		// channel extremes with a black pixel in the middle
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
		send_pixel(8'd128, 8'd64, 8'd32, 1'b1);
		// black last pixel closing a non-empty segment
		send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		// segment made only of black pixels
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		// back-to-back single pixel segments
		send_pixel(8'd3, 8'd5, 8'd7, 1'b1);
		send_pixel(8'd254, 8'd128, 8'd2, 1'b1);
		send_pixel(8'd0, 8'd0, 8'd9, 1'b1);
		// means that truncate
		send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
		send_pixel(8'd2, 8'd2, 8'd4, 1'b0);
		send_pixel(8'd2, 8'd3, 8'd4, 1'b1);
		wait_results_drained();
	endtask

	task automatic test_random_segments(input int num_pixels);
		int sent;
		int len;
		sent = 0;
		while (sent < num_pixels) begin
			// a stretch with no idling on either side
			sender_steady = (sent >= num_pixels / 3) && (sent < num_pixels / 3 + 250);
			receiver_steady = sender_steady;
			case ($urandom_range(19))
				0: len = $urandom_range(30, 120);
				1, 2: len = 1;
				default: len = $urandom_range(2, 12);
			endcase
			send_random_segment(len);
			sent += len;
		end
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
		wait_results_drained();
	endtask

	// results pile up while the receiver holds off, so the input stalls
	task automatic test_result_backpressure();
		hold_cycles = HOLD_OFF_CYCLES;
		for (int k = 0; k < 40; k++) send_random_segment($urandom_range(1, 3));
		wait_results_drained();
	endtask

	// test sequence
	initial begin
		clear_segment();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_segments();
		test_random_segments(1000);
		test_result_backpressure();
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/mrcs_pkg.sv
rtl/mrcs_accum.sv
rtl/mrcs_divider.sv
rtl/masked_rgb_channel_statistics.sv
tb/sv/masked_rgb_channel_statistics_tb.sv
